/* sv/gda_pkg.sv */
package gda_pkg;

  typedef struct packed {
    logic load;
    logic inc;
    logic dec;
  } yc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic leap;
  } yc_stat_t;

  localparam int unsigned InYearWidth  = 14;
  localparam int unsigned MonthWidth   = 4;
  localparam int unsigned DayWidth     = 5;
  localparam int unsigned OffsetWidth  = 21;
  localparam int unsigned DaySumWidth  = 22;
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 24;

  localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
  localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
  localparam logic [MonthWidth-1:0] MonthApr = 4'd4;
  localparam logic [MonthWidth-1:0] MonthJun = 4'd6;
  localparam logic [MonthWidth-1:0] MonthSep = 4'd9;
  localparam logic [MonthWidth-1:0] MonthNov = 4'd11;
  localparam logic [MonthWidth-1:0] MonthDec = 4'd12;

  localparam logic [DayWidth-1:0] DaysLong    = 5'd31;
  localparam logic [DayWidth-1:0] DaysShort   = 5'd30;
  localparam logic [DayWidth-1:0] DaysFeb     = 5'd28;
  localparam logic [DayWidth-1:0] DaysFebLeap = 5'd29;
  localparam logic [DayWidth-1:0] DaysNone    = 5'd0;

  localparam logic [InYearWidth-1:0] YearsPerCentury = 14'd100;
  localparam logic [InYearWidth-1:0] LastYearOfCent  = 14'd99;

endpackage

/* sv/gda_month_len.sv */
module gda_month_len (
  input  logic [gda_pkg::MonthWidth-1:0] month_i,
  input  logic                           leap_i,
  output logic [gda_pkg::DayWidth-1:0]   days_o
);

  always_comb begin
    case (month_i)
      gda_pkg::MonthFeb: days_o = leap_i ? gda_pkg::DaysFebLeap : gda_pkg::DaysFeb;
      gda_pkg::MonthApr,
      gda_pkg::MonthJun,
      gda_pkg::MonthSep,
      gda_pkg::MonthNov: days_o = gda_pkg::DaysShort;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      gda_pkg::MonthDec: days_o = gda_pkg::DaysLong;
      default:           days_o = gda_pkg::DaysNone;
    endcase
  end

endmodule

/* sv/gda_year_ctr.sv */
module gda_year_ctr #(
  parameter int unsigned YearWidth = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gda_pkg::yc_ctrl_t                   ctrl_i,
  input  logic [gda_pkg::InYearWidth-1:0]     year_init_i,
  output logic [YearWidth-1:0]                year_o,
  output gda_pkg::yc_stat_t                   stat_o
);

  logic [YearWidth-1:0]               year_q, year_d;
  logic [gda_pkg::InYearWidth-1:0]    rem_q, rem_d;
  logic [1:0]                         cent_q, cent_d;
  logic                               busy_q, busy_d;

  // rem_q: year mod 100 once the initial reduction finishes
  // cent_q: (year / 100) mod 4
  always_comb begin
    year_d = year_q;
    rem_d  = rem_q;
    cent_d = cent_q;
    busy_d = busy_q;
    if (ctrl_i.load) begin
      year_d = YearWidth'(year_init_i);
      rem_d  = year_init_i;
      cent_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= gda_pkg::YearsPerCentury) begin
        rem_d  = rem_q - gda_pkg::YearsPerCentury;
        cent_d = cent_q + 2'd1;
      end else begin
        busy_d = 1'b0;
      end
    end else if (ctrl_i.inc) begin
      year_d = year_q + YearWidth'(1);
      if (rem_q == gda_pkg::LastYearOfCent) begin
        rem_d  = '0;
        cent_d = cent_q + 2'd1;
      end else begin
        rem_d = rem_q + 14'd1;
      end
    end else if (ctrl_i.dec) begin
      year_d = year_q - YearWidth'(1);
      if (rem_q == '0) begin
        rem_d  = gda_pkg::LastYearOfCent;
        cent_d = cent_q - 2'd1;
      end else begin
        rem_d = rem_q - 14'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      year_q <= '0;
      rem_q  <= '0;
      cent_q <= '0;
    end else begin
      busy_q <= busy_d;
      year_q <= year_d;
      rem_q  <= rem_d;
      cent_q <= cent_d;
    end
  end

  assign year_o      = year_q;
  assign stat_o.busy = busy_q;
  assign stat_o.leap = (year_q[1:0] == 2'd0) && ((rem_q != '0) || (cent_q == 2'd0));

endmodule

/* sv/gregorian_date_add_days_top.sv */
// Channel  Dir  Fields (low bit up)
// s_axis   in   tdata: year_in[13:0] month_in[17:14] day_in[22:18] offset_days[43:23]
// m_axis   out  tdata: year_out[13:0] month_out[17:14] day_out[22:18]; tuser: out_of_range
//
// One transaction runs from acceptance to a valid result in these steps: a year-mod-100
// reduction subtracts one century per cycle, then a single day adder steps one month per
// cycle across each month boundary crossed; an invalid date skips the month steps.
// Reset clears the sequencer and the output valid; no result is pending after it.
// A stalled result waits in the output register while the next item is taken.
module gregorian_date_add_days_top #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // year_in, month_in, day_in, offset_days, zero pad
  input  logic [gda_pkg::InDataWidth-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // year_out, month_out, day_out, zero pad
  output logic [gda_pkg::OutDataWidth-1:0]     m_axis_tdata,
  // out_of_range
  output logic [0:0]                           m_axis_tuser
);

  localparam int unsigned YwRaw = $clog2(MAX_YEAR + 2);
  localparam int unsigned Yw    = (YwRaw > gda_pkg::InYearWidth) ? YwRaw
                                                                 : gda_pkg::InYearWidth;
  localparam logic [Yw-1:0] MaxYear = Yw'(MAX_YEAR);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_FWD,
    S_BWD,
    S_DONE
  } state_e;

  state_e                                state_q, state_d;
  logic [gda_pkg::InYearWidth-1:0]       y0_q, y0_d;
  logic [gda_pkg::MonthWidth-1:0]        m0_q, m0_d;
  logic [gda_pkg::DayWidth-1:0]          d0_q, d0_d;
  logic [gda_pkg::OffsetWidth-1:0]       off_q, off_d;
  logic [gda_pkg::MonthWidth-1:0]        mon_q, mon_d;
  logic [gda_pkg::DaySumWidth-1:0]       day_q, day_d;
  logic                                  bad_q, bad_d;
  logic                                  out_valid_q, out_valid_d;
  logic [gda_pkg::OutDataWidth-1:0]      out_data_q, out_data_d;
  logic                                  out_oor_q, out_oor_d;

  gda_pkg::yc_ctrl_t                     yc_ctrl;
  gda_pkg::yc_stat_t                     yc_stat;
  logic [Yw-1:0]                         year;

  logic [gda_pkg::MonthWidth-1:0]        prev_mon;
  logic [gda_pkg::MonthWidth-1:0]        len_mon;
  logic [gda_pkg::DayWidth-1:0]          mlen;
  logic [gda_pkg::DaySumWidth-1:0]       mlen_ext;
  logic [gda_pkg::DaySumWidth-1:0]       day_sum;
  logic                                  day_gt_len;
  logic                                  day_le_zero;
  logic                                  in_valid_date;
  logic                                  accept;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign prev_mon = (mon_q == gda_pkg::MonthJan) ? gda_pkg::MonthDec
                                                 : mon_q - 4'd1;
  assign len_mon  = (state_q == S_BWD) ? prev_mon : mon_q;

  gda_month_len u_month_len (
    .month_i (len_mon),
    .leap_i  (yc_stat.leap),
    .days_o  (mlen)
  );

  gda_year_ctr #(
    .YearWidth (Yw)
  ) u_year_ctr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (yc_ctrl),
    .year_init_i (y0_d),
    .year_o      (year),
    .stat_o      (yc_stat)
  );

  // shared day adder: subtract on forward steps, add on backward steps
  assign mlen_ext    = {{(gda_pkg::DaySumWidth - gda_pkg::DayWidth){1'b0}}, mlen};
  assign day_sum     = (state_q == S_FWD) ? day_q - mlen_ext : day_q + mlen_ext;
  assign day_gt_len  = $signed(day_q) > $signed(mlen_ext);
  assign day_le_zero = day_q[gda_pkg::DaySumWidth-1] || (day_q == '0);

  assign in_valid_date = (y0_q != '0) && (Yw'(y0_q) <= MaxYear) &&
                         (m0_q >= gda_pkg::MonthJan) && (m0_q <= gda_pkg::MonthDec) &&
                         (d0_q != '0) && (d0_q <= mlen);

  always_comb begin
    yc_ctrl.load = accept;
    yc_ctrl.inc  = (state_q == S_FWD) && day_gt_len && (mon_q == gda_pkg::MonthDec) &&
                   (year != MaxYear);
    yc_ctrl.dec  = (state_q == S_BWD) && day_le_zero && (mon_q == gda_pkg::MonthJan) &&
                   (year != Yw'(1));
  end

  always_comb begin
    state_d     = state_q;
    y0_d        = y0_q;
    m0_d        = m0_q;
    d0_d        = d0_q;
    off_d       = off_q;
    mon_d       = mon_q;
    day_d       = day_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_oor_d   = out_oor_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          y0_d    = s_axis_tdata[13:0];
          m0_d    = s_axis_tdata[17:14];
          d0_d    = s_axis_tdata[22:18];
          off_d   = s_axis_tdata[43:23];
          mon_d   = s_axis_tdata[17:14];
          bad_d   = 1'b0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (!yc_stat.busy) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!in_valid_date) begin
          bad_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          day_d   = {{(gda_pkg::DaySumWidth - gda_pkg::DayWidth){1'b0}}, d0_q} +
                    {off_q[gda_pkg::OffsetWidth-1], off_q};
          state_d = off_q[gda_pkg::OffsetWidth-1] ? S_BWD : S_FWD;
        end
      end
      S_FWD: begin
        if (day_gt_len) begin
          day_d = day_sum;
          if (mon_q == gda_pkg::MonthDec) begin
            mon_d = gda_pkg::MonthJan;
            if (year == MaxYear) begin
              bad_d   = 1'b1;
              state_d = S_DONE;
            end
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_BWD: begin
        if (day_le_zero) begin
          mon_d = prev_mon;
          day_d = day_sum;
          if ((mon_q == gda_pkg::MonthJan) && (year == Yw'(1))) begin
            bad_d   = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_oor_d   = bad_q;
          out_data_d  = bad_q ? {1'b0, d0_q, m0_q, y0_q}
                              : {1'b0, day_q[gda_pkg::DayWidth-1:0], mon_q,
                                 year[gda_pkg::InYearWidth-1:0]};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      y0_q        <= '0;
      m0_q        <= '0;
      d0_q        <= '0;
      off_q       <= '0;
      mon_q       <= '0;
      day_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      y0_q        <= y0_d;
      m0_q        <= m0_d;
      d0_q        <= d0_d;
      off_q       <= off_d;
      mon_q       <= mon_d;
      day_q       <= day_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_oor_q   <= out_oor_d;
    end
  end

  assign s_axis_tready   = (state_q == S_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_oor_q;

endmodule
